@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the planner core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MCP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MCP_ASSERT(label, clk, rst_n, prop, msg)
`define MCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/mcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Mip chain copy planner package
// Widths, codes, level geometry helpers and shared structs.
// ----------------------------------------------------------------------------
package mcp_pkg;

	localparam int MAX_DIMENSION = 16384;
	localparam int ROW_ALIGN     = 256;
	localparam int LEVEL_ALIGN   = 512;

	localparam int FMT_W      = 4;
	localparam int DIM_W      = 15;
	localparam int LVL_W      = 4;
	localparam int SIZE_W     = 34;
	localparam int SROW_W     = SIZE_W + 1;
	localparam int LEN_W      = 18;
	localparam int ROWCNT_W   = 15;
	localparam int ROW_W      = 14;
	localparam int PROD_W     = LEN_W + ROWCNT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SIZE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE  = 3'd4;

	localparam logic [FMT_W-1:0] FMT_R8      = 4'd0;
	localparam logic [FMT_W-1:0] FMT_RGBA8_A = 4'd1;
	localparam logic [FMT_W-1:0] FMT_RGBA8_B = 4'd2;
	localparam logic [FMT_W-1:0] FMT_RGBA16F = 4'd3;
	localparam logic [FMT_W-1:0] FMT_BC1_A   = 4'd4;
	localparam logic [FMT_W-1:0] FMT_BC1_B   = 4'd5;
	localparam logic [FMT_W-1:0] FMT_BC4     = 4'd6;
	localparam logic [FMT_W-1:0] FMT_BC3_A   = 4'd7;
	localparam logic [FMT_W-1:0] FMT_BC3_B   = 4'd8;
	localparam logic [FMT_W-1:0] FMT_BC5     = 4'd9;
	localparam logic [FMT_W-1:0] FMT_BC7_A   = 4'd10;
	localparam logic [FMT_W-1:0] FMT_BC7_B   = 4'd11;

	typedef enum logic [1:0] {
		KIND_COPY  = 2'd0,
		KIND_CUT   = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SYNC_IDLE,
		SYNC_GEOM,
		SYNC_MUL,
		SYNC_ADD
	} sync_t;

	typedef struct packed {
		logic       known;
		logic       compressed;
		logic [2:0] shift;
	} fmt_info_t;

	typedef struct packed {
		logic [LEN_W-1:0]    tight;
		logic [ROWCNT_W-1:0] rows;
		logic [LEN_W-1:0]    pitch;
	} geom_t;

	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		geom_t             geom;
		logic [PROD_W-1:0] prod_pr;
		logic [PROD_W-1:0] prod_tr;
	} l0_t;

	typedef struct packed {
		logic [FMT_W-1:0]  fmt;
		logic [LVL_W-1:0]  level_count;
		logic [SIZE_W-1:0] source_size;
	} cfg_t;

	function automatic fmt_info_t fmt_info(input logic [FMT_W-1:0] fmt);
		fmt_info_t fi;
		fi = '{known: 1'b1, compressed: 1'b0, shift: 3'd0};
		case (fmt)
			FMT_R8:                           fi.shift = 3'd0;
			FMT_RGBA8_A, FMT_RGBA8_B:         fi.shift = 3'd2;
			FMT_RGBA16F:                      fi.shift = 3'd3;
			FMT_BC1_A, FMT_BC1_B, FMT_BC4: begin
				fi.shift      = 3'd3;
				fi.compressed = 1'b1;
			end
			FMT_BC3_A, FMT_BC3_B, FMT_BC5, FMT_BC7_A, FMT_BC7_B: begin
				fi.shift      = 3'd4;
				fi.compressed = 1'b1;
			end
			default:                          fi.known = 1'b0;
		endcase
		return fi;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : v;
	endfunction

	function automatic logic [DIM_W-1:0] halve_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] half;
		half = v >> 1;
		return (half == '0) ? DIM_W'(1) : half;
	endfunction

	function automatic geom_t level_geom(input logic [FMT_W-1:0] fmt,
			input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		fmt_info_t        fi;
		logic [DIM_W:0]   w3;
		logic [DIM_W:0]   h3;
		logic [LEN_W-1:0] units;
		logic [LEN_W-1:0] pad;
		geom_t            g;
		fi    = fmt_info(fmt);
		w3    = {1'b0, w} + (DIM_W+1)'(3);
		h3    = {1'b0, h} + (DIM_W+1)'(3);
		units = fi.compressed ? LEN_W'(w3[DIM_W:2]) : LEN_W'(w);
		g.tight = fi.known ? (units << fi.shift) : '0;
		g.rows  = fi.compressed ? ROWCNT_W'(h3[DIM_W:2]) : ROWCNT_W'(h);
		pad     = g.tight + LEN_W'(ROW_ALIGN - 1);
		g.pitch = pad & ~LEN_W'(ROW_ALIGN - 1);
		return g;
	endfunction

	function automatic logic [SIZE_W-1:0] level_start(input logic [SIZE_W-1:0] v);
		logic [SIZE_W:0] s;
		s = {1'b0, v} + (SIZE_W+1)'(LEVEL_ALIGN - 1);
		s = s & ~((SIZE_W+1)'(LEVEL_ALIGN - 1));
		return s[SIZE_W-1:0];
	endfunction

endpackage

@@ rtl/mcp_if.sv @@
// ----------------------------------------------------------------------------
// Planner channel interfaces
// Request channel (restart flag) and result channel (row copy descriptor).
// ----------------------------------------------------------------------------
interface mcp_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mcp_rsp_if;
	logic                              valid;
	logic                              ready;
	mcp_pkg::kind_t                    kind;
	logic [mcp_pkg::SIZE_W-1:0]        src_offset;
	logic [mcp_pkg::SIZE_W-1:0]        dest_offset;
	logic [mcp_pkg::LEN_W-1:0]         copy_length;
	logic [mcp_pkg::LVL_W-1:0]         mip_level;
	logic [mcp_pkg::ROW_W-1:0]         row_index;
	logic [mcp_pkg::SIZE_W-1:0]        buffer_size;

	modport source (output valid, output kind, output src_offset, output dest_offset,
		output copy_length, output mip_level, output row_index, output buffer_size,
		input ready);
	modport sink (input valid, input kind, input src_offset, input dest_offset,
		input copy_length, input mip_level, input row_index, input buffer_size,
		output ready);
endinterface

@@ rtl/mcp_cfg.sv @@
// ----------------------------------------------------------------------------
// Planner configuration registers
// Holds the register file and keeps level zero geometry and its products
// precomputed for rewinds.
// ----------------------------------------------------------------------------
module mcp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output mcp_pkg::cfg_t                 cfg,
	output mcp_pkg::l0_t                  l0
);
	import mcp_pkg::*;

	logic [FMT_W-1:0]  fmt_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [LVL_W-1:0]  lvl_cnt_q;
	logic [SIZE_W-1:0] src_size_q;

	logic [DIM_W-1:0]  w0_s1;
	logic [DIM_W-1:0]  h0_s1;
	geom_t             geom_s1;
	logic [PROD_W-1:0] prod_pr_s2;
	logic [PROD_W-1:0] prod_tr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_RGBA8_A;
			width_q    <= DIM_W'(1);
			height_q   <= DIM_W'(1);
			lvl_cnt_q  <= LVL_W'(1);
			src_size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PIXEL_FORMAT: fmt_q      <= cfg_wdata[FMT_W-1:0];
				CFG_BASE_WIDTH:   width_q    <= cfg_wdata[DIM_W-1:0];
				CFG_BASE_HEIGHT:  height_q   <= cfg_wdata[DIM_W-1:0];
				CFG_LEVEL_COUNT:  lvl_cnt_q  <= cfg_wdata[LVL_W-1:0];
				CFG_SOURCE_SIZE:  src_size_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// level zero geometry, then its products
	always_ff @(posedge clk) begin
		w0_s1      <= clamp_dim(width_q);
		h0_s1      <= clamp_dim(height_q);
		geom_s1    <= level_geom(fmt_q, clamp_dim(width_q), clamp_dim(height_q));
		prod_pr_s2 <= PROD_W'(geom_s1.pitch) * PROD_W'(geom_s1.rows);
		prod_tr_s2 <= PROD_W'(geom_s1.tight) * PROD_W'(geom_s1.rows);
	end

	assign cfg.fmt         = fmt_q;
	assign cfg.level_count = lvl_cnt_q;
	assign cfg.source_size = src_size_q;

	assign l0.w       = w0_s1;
	assign l0.h       = h0_s1;
	assign l0.geom    = geom_s1;
	assign l0.prod_pr = prod_pr_s2;
	assign l0.prod_tr = prod_tr_s2;

endmodule

@@ rtl/mcp_core.sv @@
// ----------------------------------------------------------------------------
// Planner core
// Chain state, per-level setup sequence, one-pass row planning and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  mcp_pkg::cfg_t cfg,
	input  mcp_pkg::l0_t  l0,
	mcp_req_if.sink       req,
	mcp_rsp_if.source     rsp
);
	import mcp_pkg::*;

	sync_t phase_q, phase_d;

	logic [LVL_W-1:0]    level_q;
	logic [ROWCNT_W-1:0] row_q;
	logic [DIM_W-1:0]    w_q;
	logic [DIM_W-1:0]    h_q;
	logic [SIZE_W-1:0]   src_base_q;
	logic [SIZE_W-1:0]   dst_base_q;
	logic                done_q;
	logic                rsp_valid_q;

	geom_t               geom_q;
	logic [SIZE_W-1:0]   start_q;
	logic [PROD_W-1:0]   prod_pr_q;
	logic [PROD_W-1:0]   prod_tr_q;
	logic [PROD_W-1:0]   rt_q;
	logic [PROD_W-1:0]   rp_q;
	logic [SROW_W-1:0]   src_row_q;
	logic [SIZE_W-1:0]   dst_row_q;

	kind_t               kind_q;
	logic [SIZE_W-1:0]   src_off_q;
	logic [SIZE_W-1:0]   dst_off_q;
	logic [LEN_W-1:0]    len_q;
	logic [LVL_W-1:0]    lvl_out_q;
	logic [ROW_W-1:0]    row_out_q;
	logic [SIZE_W-1:0]   buf_q;

	// effective state after an optional rewind
	logic [LVL_W-1:0]    e_level;
	logic [ROWCNT_W-1:0] e_row;
	logic [DIM_W-1:0]    e_w;
	logic [DIM_W-1:0]    e_h;
	logic [SIZE_W-1:0]   e_sb;
	logic [SIZE_W-1:0]   e_db;
	logic                e_done;
	geom_t               e_geom;
	logic [SIZE_W-1:0]   e_start;
	logic [PROD_W-1:0]   e_ppr;
	logic [PROD_W-1:0]   e_ptr;
	logic [SROW_W-1:0]   e_srow;
	logic [SIZE_W-1:0]   e_drow;

	logic                acc;
	logic                fin;
	logic                empty;
	logic                cut;
	logic                last_row;
	logic                lvl_end;
	logic [SIZE_W-1:0]   required;
	logic [SROW_W:0]     row_end;
	logic [ROWCNT_W:0]   row_nx;
	kind_t               kind_d;
	logic [SIZE_W-1:0]   src_off_d;
	logic [SIZE_W-1:0]   dst_off_d;
	logic [LEN_W-1:0]    len_d;
	logic [ROW_W-1:0]    row_out_d;
	logic [SIZE_W-1:0]   buf_d;

	assign acc = req.valid && req.ready;

	always_comb begin
		if (req.restart) begin
			e_level = '0;
			e_row   = '0;
			e_w     = l0.w;
			e_h     = l0.h;
			e_sb    = '0;
			e_db    = '0;
			e_done  = 1'b0;
			e_geom  = l0.geom;
			e_start = '0;
			e_ppr   = l0.prod_pr;
			e_ptr   = l0.prod_tr;
			e_srow  = '0;
			e_drow  = '0;
		end else begin
			e_level = level_q;
			e_row   = row_q;
			e_w     = w_q;
			e_h     = h_q;
			e_sb    = src_base_q;
			e_db    = dst_base_q;
			e_done  = done_q;
			e_geom  = geom_q;
			e_start = start_q;
			e_ppr   = prod_pr_q;
			e_ptr   = prod_tr_q;
			e_srow  = src_row_q;
			e_drow  = dst_row_q;
		end
	end

	always_comb begin
		fin      = e_done || (e_level >= cfg.level_count);
		empty    = (e_geom.rows == '0) || (e_geom.tight == '0);
		required = e_start + SIZE_W'(e_ppr);
		row_end  = {1'b0, e_srow} + (SROW_W+1)'(e_geom.tight);
		cut      = row_end > (SROW_W+1)'(cfg.source_size);
		row_nx   = {1'b0, e_row} + (ROWCNT_W+1)'(1);
		last_row = row_nx >= {1'b0, e_geom.rows};

		kind_d    = KIND_DONE;
		src_off_d = e_sb;
		dst_off_d = e_db;
		len_d     = '0;
		row_out_d = '0;
		buf_d     = e_db;
		lvl_end   = 1'b0;
		if (!fin) begin
			buf_d     = required;
			dst_off_d = e_start;
			if (empty) begin
				kind_d  = KIND_EMPTY;
				lvl_end = 1'b1;
			end else if (cut) begin
				kind_d    = KIND_CUT;
				row_out_d = e_row[ROW_W-1:0];
				lvl_end   = 1'b1;
			end else begin
				kind_d    = KIND_COPY;
				src_off_d = e_srow[SIZE_W-1:0];
				dst_off_d = e_drow;
				len_d     = e_geom.tight;
				row_out_d = e_row[ROW_W-1:0];
				lvl_end   = last_row;
			end
		end
	end

	// setup sequence: geometry, products, row offsets
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			SYNC_IDLE: if (acc && lvl_end) phase_d = SYNC_GEOM;
			SYNC_GEOM: phase_d = SYNC_MUL;
			SYNC_MUL:  phase_d = SYNC_ADD;
			SYNC_ADD:  phase_d = SYNC_IDLE;
			default:   phase_d = SYNC_IDLE;
		endcase
		if (cfg_we) phase_d = SYNC_GEOM;
	end

	always_comb begin
		req.ready = (phase_q == SYNC_IDLE) && (!rsp_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= SYNC_GEOM;
			rsp_valid_q <= 1'b0;
			level_q     <= '0;
			row_q       <= '0;
			w_q         <= DIM_W'(1);
			h_q         <= DIM_W'(1);
			src_base_q  <= '0;
			dst_base_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (acc) begin
				done_q <= fin;
				if (lvl_end) begin
					level_q    <= e_level + LVL_W'(1);
					row_q      <= '0;
					w_q        <= halve_dim(e_w);
					h_q        <= halve_dim(e_h);
					src_base_q <= e_sb + SIZE_W'(e_ptr);
					dst_base_q <= required;
				end else begin
					level_q    <= e_level;
					row_q      <= fin ? e_row : row_nx[ROWCNT_W-1:0];
					w_q        <= e_w;
					h_q        <= e_h;
					src_base_q <= e_sb;
					dst_base_q <= e_db;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q    <= kind_d;
			src_off_q <= src_off_d;
			dst_off_q <= dst_off_d;
			len_q     <= len_d;
			lvl_out_q <= e_level;
			row_out_q <= row_out_d;
			buf_q     <= buf_d;
			geom_q    <= e_geom;
			start_q   <= e_start;
			prod_pr_q <= e_ppr;
			prod_tr_q <= e_ptr;
			src_row_q <= e_srow + SROW_W'(e_geom.tight);
			dst_row_q <= e_drow + SIZE_W'(e_geom.pitch);
		end
		case (phase_q)
			SYNC_GEOM: begin
				geom_q  <= level_geom(cfg.fmt, w_q, h_q);
				start_q <= level_start(dst_base_q);
			end
			SYNC_MUL: begin
				prod_pr_q <= PROD_W'(geom_q.pitch) * PROD_W'(geom_q.rows);
				prod_tr_q <= PROD_W'(geom_q.tight) * PROD_W'(geom_q.rows);
				rt_q      <= PROD_W'(row_q) * PROD_W'(geom_q.tight);
				rp_q      <= PROD_W'(row_q) * PROD_W'(geom_q.pitch);
			end
			SYNC_ADD: begin
				src_row_q <= {1'b0, src_base_q} + SROW_W'(rt_q);
				dst_row_q <= start_q + SIZE_W'(rp_q);
			end
			default: ;
		endcase
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.src_offset  = src_off_q;
	assign rsp.dest_offset = dst_off_q;
	assign rsp.copy_length = len_q;
	assign rsp.mip_level   = lvl_out_q;
	assign rsp.row_index   = row_out_q;
	assign rsp.buffer_size = buf_q;

	`MCP_ASSERT(a_copy_len, clk, arst_n, rsp_valid_q && (kind_q == KIND_COPY) |-> (len_q != '0), "row copy beat with zero length")
	`MCP_ASSERT_NEXT(a_cfg_setup, clk, arst_n, cfg_we, phase_q == SYNC_GEOM, "config write did not start level setup")
	`MCP_ASSERT_NEXT(a_row_step, clk, arst_n, acc && !req.restart && (kind_d == KIND_COPY) && !lvl_end, row_q == $past(row_q) + ROWCNT_W'(1), "row did not advance after copy")
	`MCP_ASSERT_NEXT(a_done_hold, clk, arst_n, done_q && !(acc && req.restart), done_q, "finished chain left without restart")

endmodule

@@ rtl/mip_chain_pitch_copy_planner_top.sv @@
// ----------------------------------------------------------------------------
// Mip chain pitch copy planner
// Plans row copies that repack a tight mip chain into a pitched layout.
// ----------------------------------------------------------------------------
// Output: a result is registered, valid the cycle after its request beat.
// Throughput: one beat per cycle within a level unless rsp.ready stalls; each
//   level change and each config write runs level setup (geometry, multiplies
//   and offset adds). Reset: arst_n clears control state and starts setup;
//   the first request is taken once that setup has finished.
module mip_chain_pitch_copy_planner_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mcp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mcp_req_if.sink                        req,
	mcp_rsp_if.source                      rsp
);
	import mcp_pkg::*;

	cfg_t cfg;
	l0_t  l0;

	mcp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.l0        (l0)
	);

	mcp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg    (cfg),
		.l0     (l0),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
